/* hdl/u8dec_pkg.sv */
// Shared types, constants and lead byte classification for the UTF-8 decoder.
`default_nettype none

package u8dec_pkg;

	localparam int BYTE_W = 8;
	localparam int CP_W   = 21;
	localparam int WIN_N  = 4;
	localparam int HOLD_N = 3;

	localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

	// Bytes looked at by the decode unit, starting at a lead.
	typedef struct packed {
		logic [WIN_N-1:0][BYTE_W-1:0] bytes;
		logic [2:0]                   avail;
	} win_t;

	// What the decode unit makes of a window.
	typedef struct packed {
		logic [CP_W-1:0] cp;
		logic [2:0]      used;
	} res_t;

	// Number of continuation bytes a lead asks for; zero if it is no multi-byte lead.
	function automatic logic [1:0] lead_need(input logic [BYTE_W-1:0] b);
		logic [1:0] need;
		need = 2'd0;
		if ((b & 8'hE0) == 8'hC0) begin
			need = 2'd1;
		end else if ((b & 8'hF0) == 8'hE0) begin
			need = 2'd2;
		end else if ((b & 8'hF8) == 8'hF0) begin
			need = 2'd3;
		end
		return need;
	endfunction

endpackage

`default_nettype wire

/* hdl/utf8_codepoint_decoder.sv */
// Top level of the UTF-8 decoder: byte hold buffer, sequencer and output register.
// A result appears in the output register in the cycle after the byte transfer.
// Throughput: one byte per cycle while the output register is free; an end of string
// that cuts a sequence short yields up to three results, one per cycle while the output
// register is free, the later ones from the shared decode unit, and no byte is taken until the last of them is loaded.
// Reset clears the held count, the sequencer and the output valid; held bytes are not reset.
`default_nettype none

module utf8_codepoint_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        text_valid,
	output logic             text_stall,
	input  wire logic [7:0]  text_byte,
	output logic             cp_valid,
	input  wire logic        cp_stall,
	output logic [20:0]      code_point,
	output logic             has_code_point,
	output logic             end_of_string
);

	// Sequencer: IDLE takes bytes, DRAIN re-decodes the held bytes after a cut-short lead.
	typedef enum logic [1:0] {
		ST_IDLE  = 2'b01,
		ST_DRAIN = 2'b10
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] pend_cnt_q, pend_cnt_d;    // bytes held, lead included
	logic [1:0] need_cnt_q, need_cnt_d;    // continuation bytes the held lead asks for
	logic [1:0] pos_q, pos_d;              // next held byte to decode while draining
	logic [7:0] pend_q [u8dec_pkg::HOLD_N];

	logic        out_valid_q;
	logic [20:0] out_cp_q;
	logic        out_has_q;
	logic        out_end_q;

	logic        out_free;
	logic        take;
	logic        load;
	logic [20:0] cp_d;
	logic        has_d;
	logic        end_d;
	logic        pend_we;
	logic [2:0]  next_pos;

	u8dec_pkg::win_t win;
	u8dec_pkg::res_t res;

	// The output register is free when it is empty or its result leaves in this cycle.
	assign out_free   = !out_valid_q || !cp_stall;
	assign text_stall = (state_q != ST_IDLE) || !out_free;
	assign take       = text_valid && !text_stall;

	// Window for the shared unit. While idle it is the held bytes with the new byte
	// appended; while draining it starts at the next held byte not yet decoded.
	always_comb begin
		win = '0;
		if (state_q == ST_DRAIN) begin
			win.bytes[0] = pend_q[pos_q];
			win.bytes[1] = (pos_q == 2'd1) ? pend_q[2] : 8'd0;
			win.avail    = {1'b0, pend_cnt_q} - {1'b0, pos_q};
		end else begin
			for (int i = 0; i < u8dec_pkg::HOLD_N; i++) begin
				if (2'(i) < pend_cnt_q) begin
					win.bytes[i] = pend_q[i];
				end else if (2'(i) == pend_cnt_q) begin
					win.bytes[i] = text_byte;
				end
			end
			win.bytes[3] = (pend_cnt_q == 2'd3) ? text_byte : 8'd0;
			win.avail    = {1'b0, pend_cnt_q} + 3'd1;
		end
	end

	u8dec_unit u_unit (
		.win (win),
		.res (res)
	);

	assign next_pos = {1'b0, pos_q} + res.used;

	// Sequencer decisions for the current cycle.
	always_comb begin
		state_d    = state_q;
		pend_cnt_d = pend_cnt_q;
		need_cnt_d = need_cnt_q;
		pos_d      = pos_q;
		load       = 1'b0;
		cp_d       = res.cp;
		has_d      = 1'b1;
		end_d      = 1'b0;
		pend_we    = 1'b0;
		if (take) begin
			if (text_byte == 8'd0) begin
				load = 1'b1;
				if (pend_cnt_q == 2'd0) begin
					// End of string with nothing held: a bare end marker.
					cp_d  = '0;
					has_d = 1'b0;
					end_d = 1'b1;
				end else begin
					// The held lead is cut short and gives the replacement character.
					cp_d = u8dec_pkg::REPLACEMENT_CP;
					if (pend_cnt_q == 2'd1) begin
						end_d      = 1'b1;
						pend_cnt_d = 2'd0;
						need_cnt_d = 2'd0;
					end else begin
						state_d = ST_DRAIN;
						pos_d   = 2'd1;
					end
				end
			end else if (pend_cnt_q == 2'd0) begin
				need_cnt_d = u8dec_pkg::lead_need(text_byte);
				if (need_cnt_d != 2'd0) begin
					pend_we    = 1'b1;
					pend_cnt_d = 2'd1;
				end else begin
					load = 1'b1;
				end
			end else if (pend_cnt_q >= need_cnt_q) begin
				// This byte completes the held sequence.
				load       = 1'b1;
				pend_cnt_d = 2'd0;
				need_cnt_d = 2'd0;
			end else begin
				pend_we    = 1'b1;
				pend_cnt_d = pend_cnt_q + 2'd1;
			end
		end else if (state_q == ST_DRAIN && out_free) begin
			load = 1'b1;
			if (next_pos >= {1'b0, pend_cnt_q}) begin
				end_d      = 1'b1;
				state_d    = ST_IDLE;
				pend_cnt_d = 2'd0;
				need_cnt_d = 2'd0;
			end else begin
				pos_d = next_pos[1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pend_cnt_q  <= 2'd0;
			need_cnt_q  <= 2'd0;
			pos_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			pend_cnt_q <= pend_cnt_d;
			need_cnt_q <= need_cnt_d;
			pos_q      <= pos_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!cp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Held bytes and the result payload carry no reset.
	always_ff @(posedge clk) begin
		if (pend_we) begin
			pend_q[pend_cnt_q] <= text_byte;
		end
		if (load) begin
			out_cp_q  <= cp_d;
			out_has_q <= has_d;
			out_end_q <= end_d;
		end
	end

	assign cp_valid       = out_valid_q;
	assign code_point     = out_cp_q;
	assign has_code_point = out_has_q;
	assign end_of_string  = out_end_q;

endmodule

`default_nettype wire

/* hdl/u8dec_unit.sv */
// Shared decode unit: turns one window of bytes into a code point.
`default_nettype none

module u8dec_unit (
	input  wire u8dec_pkg::win_t win,
	output u8dec_pkg::res_t      res
);

	logic [7:0] b0, b1, b2, b3;
	logic [1:0] need;

	assign b0   = win.bytes[0];
	assign b1   = win.bytes[1];
	assign b2   = win.bytes[2];
	assign b3   = win.bytes[3];
	assign need = u8dec_pkg::lead_need(b0);

	always_comb begin
		res.cp   = u8dec_pkg::REPLACEMENT_CP;
		res.used = 3'd1;
		if (!b0[7]) begin
			res.cp = {13'd0, b0};
		end else if (need == 2'd1 && win.avail >= 3'd2) begin
			res.cp   = {10'd0, b0[4:0], b1[5:0]};
			res.used = 3'd2;
		end else if (need == 2'd2 && win.avail >= 3'd3) begin
			res.cp   = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
			res.used = 3'd3;
		end else if (need == 2'd3 && win.avail >= 3'd4) begin
			res.cp   = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
			res.used = 3'd4;
		end
	end

endmodule

`default_nettype wire

/* hdl/u8dec_checker.sv */
// Port-level checks on the UTF-8 decoder and their binding to the top level.
`default_nettype none

module u8dec_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        text_valid,
	input wire logic        text_stall,
	input wire logic [7:0]  text_byte,
	input wire logic        cp_valid,
	input wire logic        cp_stall,
	input wire logic [20:0] code_point,
	input wire logic        has_code_point,
	input wire logic        end_of_string
);

	// A waiting result blocks further byte transfers.
	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		cp_valid && cp_stall |-> text_stall)
		else $error("byte taken while a result was held");

	// The zero byte always yields a result in the next cycle.
	a_end_result: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && !text_stall && text_byte == 8'd0 |=> cp_valid)
		else $error("no result after end of string");

	// A bare marker only ever closes a string.
	a_bare_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		cp_valid && !has_code_point |-> end_of_string && code_point == 21'd0)
		else $error("bare marker without end flag or with a code point");

	// A stalled result stays valid, with its code point and end flag unchanged.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		cp_valid && cp_stall |=> cp_valid && $stable(code_point) && $stable(end_of_string))
		else $error("stalled result changed");

endmodule

bind utf8_codepoint_decoder u8dec_checker u_u8dec_checker (.*);

`default_nettype wire
